### rtl/bsdp_pkg.sv
// shared types, constants and helpers for the beam sensor position decoder
`default_nettype none

package bsdp_pkg;

	// timer width and saturation value
	localparam int TIMER_BITS = 16;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// width used when a timer is compared with a 16 bit setting
	localparam int CFG_BITS = 16;
	localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

	localparam int SENSORS = 3;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_DEBOUNCE   = 2'd0,
		CFG_POLL       = 2'd1,
		CFG_BOOT_BLANK = 2'd2,
		CFG_ACTIVE_LOW = 2'd3
	} cfg_idx_t;

	// decoded position codes
	typedef enum logic [2:0] {
		POS_NONE     = 3'd0,
		POS_FLOOR1   = 3'd1,
		POS_FLOOR2   = 3'd2,
		POS_FLOOR3   = 3'd3,
		POS_BETWEEN12 = 3'd4,
		POS_BETWEEN23 = 3'd5,
		POS_ERROR    = 3'd6
	} pos_t;

	// current configuration
	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_ms;
		logic [CFG_BITS-1:0] poll_period_ms;
		logic [CFG_BITS-1:0] boot_blank_ms;
		logic                active_low;
	} cfg_t;

	// per-tick result from the tracker
	typedef struct packed {
		logic               changed;
		logic [SENSORS-1:0] bits;
	} res_t;

	// saturating timer increment
	function automatic logic [TIMER_BITS-1:0] timer_inc(input logic [TIMER_BITS-1:0] t);
		return (t == TIMER_MAX) ? t : t + TIMER_BITS'(1);
	endfunction

	// timer >= setting, both zero extended
	function automatic logic timer_ge(input logic [TIMER_BITS-1:0] t,
		input logic [CFG_BITS-1:0] lim);
		return CMP_BITS'(t) >= CMP_BITS'(lim);
	endfunction

endpackage

`default_nettype wire

### rtl/bsdp_cfg.sv
// configuration registers of the beam sensor position decoder
`default_nettype none

module bsdp_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output bsdp_pkg::cfg_t          cfg
);

	bsdp_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// register write on each configuration transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms    <= 16'd30;
			cfg_q.poll_period_ms <= 16'd50;
			cfg_q.boot_blank_ms  <= 16'd200;
			cfg_q.active_low     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (bsdp_pkg::cfg_idx_t'(cfg_index))
				bsdp_pkg::CFG_DEBOUNCE:   cfg_q.debounce_ms    <= cfg_data;
				bsdp_pkg::CFG_POLL:       cfg_q.poll_period_ms <= cfg_data;
				bsdp_pkg::CFG_BOOT_BLANK: cfg_q.boot_blank_ms  <= cfg_data;
				bsdp_pkg::CFG_ACTIVE_LOW: cfg_q.active_low     <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/bsdp_track.sv
// debounce, boot blanking and poll timers with the stored sensor bits
`default_nettype none

module bsdp_track (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire bsdp_pkg::cfg_t                   cfg,
	input  wire logic                             accept,
	input  wire logic [bsdp_pkg::SENSORS-1:0]     pin_levels,
	input  wire logic                             edge_seen,
	output bsdp_pkg::res_t                        res
);

	logic [bsdp_pkg::SENSORS-1:0]    stored_q;
	logic                            started_q;
	logic                            pending_q;
	logic [bsdp_pkg::TIMER_BITS-1:0] since_edge_q;
	logic [bsdp_pkg::TIMER_BITS-1:0] since_poll_q;
	logic [bsdp_pkg::TIMER_BITS-1:0] since_reset_q;

	logic [bsdp_pkg::SENSORS-1:0]    stored_d;
	logic                            pending_d;
	logic [bsdp_pkg::TIMER_BITS-1:0] since_edge_d;
	logic [bsdp_pkg::TIMER_BITS-1:0] since_poll_d;
	logic [bsdp_pkg::TIMER_BITS-1:0] since_reset_d;
	logic [bsdp_pkg::SENSORS-1:0]    sensed;
	logic                            waiting;
	logic                            poll_due;
	logic                            take;
	logic                            changed;

	assign sensed = cfg.active_low ? ~pin_levels : pin_levels;

	// next state for one tick
	always_comb begin
		stored_d      = stored_q;
		pending_d     = pending_q;
		since_edge_d  = since_edge_q;
		since_poll_d  = since_poll_q;
		since_reset_d = since_reset_q;
		waiting       = 1'b0;
		poll_due      = 1'b0;
		take          = 1'b0;
		changed       = 1'b0;
		if (!started_q) begin
			// first tick loads the snapshot quietly
			stored_d      = sensed;
			pending_d     = 1'b0;
			since_edge_d  = '0;
			since_poll_d  = '0;
			since_reset_d = '0;
		end else begin
			since_reset_d = bsdp_pkg::timer_inc(since_reset_q);
			since_edge_d  = bsdp_pkg::timer_inc(since_edge_q);
			since_poll_d  = bsdp_pkg::timer_inc(since_poll_q);
			// edge outside boot blanking arms a snapshot
			if (edge_seen && bsdp_pkg::timer_ge(since_reset_d, cfg.boot_blank_ms)) begin
				pending_d    = 1'b1;
				since_edge_d = '0;
			end
			waiting  = pending_d && !bsdp_pkg::timer_ge(since_edge_d, cfg.debounce_ms);
			poll_due = !waiting && bsdp_pkg::timer_ge(since_poll_d, cfg.poll_period_ms);
			take     = (pending_d && !waiting) || poll_due;
			if (pending_d && !waiting) begin
				pending_d = 1'b0;
			end
			if (poll_due) begin
				since_poll_d = '0;
			end
			// both samples see the same pins, so one compare covers them
			if (take && (sensed != stored_q)) begin
				stored_d = sensed;
				changed  = 1'b1;
			end
		end
	end

	assign res.changed = changed;
	assign res.bits    = stored_d;

	// state update on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q      <= '0;
			started_q     <= 1'b0;
			pending_q     <= 1'b0;
			since_edge_q  <= '0;
			since_poll_q  <= '0;
			since_reset_q <= '0;
		end else if (accept) begin
			stored_q      <= stored_d;
			started_q     <= 1'b1;
			pending_q     <= pending_d;
			since_edge_q  <= since_edge_d;
			since_poll_q  <= since_poll_d;
			since_reset_q <= since_reset_d;
		end
	end

	// a reported change really moves the stored bits
	a_change_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.changed) |=> (stored_q != $past(stored_q)))
		else $error("changed raised without new stored bits");

	// after the first tick the stored bits move only with a reported change
	a_quiet_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && started_q && !res.changed) |=> (stored_q == $past(stored_q)))
		else $error("stored bits moved without changed");

	// the first tick never reports a change and clears the reset and poll timers
	a_first_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !started_q) |-> !res.changed ##1
		(started_q && !pending_q && since_reset_q == '0 && since_poll_q == '0))
		else $error("first tick handled wrong");

endmodule

`default_nettype wire

### rtl/bsdp_decode.sv
// position decode of the three detected bits
`default_nettype none

module bsdp_decode (
	input  wire logic [bsdp_pkg::SENSORS-1:0] bits,
	output bsdp_pkg::pos_t                    code
);

	// single bit gives its floor, adjacent pairs give between codes
	always_comb begin
		unique case (bits)
			3'b000:  code = bsdp_pkg::POS_NONE;
			3'b001:  code = bsdp_pkg::POS_FLOOR1;
			3'b010:  code = bsdp_pkg::POS_FLOOR2;
			3'b100:  code = bsdp_pkg::POS_FLOOR3;
			3'b011:  code = bsdp_pkg::POS_BETWEEN12;
			3'b110:  code = bsdp_pkg::POS_BETWEEN23;
			default: code = bsdp_pkg::POS_ERROR;
		endcase
	end

endmodule

`default_nettype wire

### rtl/beam_sensor_debounce_position_decode_core.sv
// top level of the debounced three-sensor beam position decoder
// an accepted tick's result is captured in the output register in the cycle after its acceptance
// throughput: one tick per cycle while the output register is not stalled; the state
// update and decode sit between the tracker state registers and the output register
// s_tready is high whenever the output register is empty or is taken this cycle
// reset: asynchronous active low, clears the state and the output valid, loads config defaults
`default_nettype none

module beam_sensor_debounce_position_decode_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [2:0] pin_levels, [3] edge_seen, [7:4] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [0] changed, [3:1] detected_bits, [6:4] position_code, [7] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	bsdp_pkg::cfg_t  cfg;
	bsdp_pkg::res_t  res;
	bsdp_pkg::pos_t  code;
	logic            accept;
	logic            out_valid_q;
	logic [7:0]      out_data_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	bsdp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bsdp_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.accept     (accept),
		.pin_levels (s_tdata[2:0]),
		.edge_seen  (s_tdata[3]),
		.res        (res)
	);

	bsdp_decode u_decode (
		.bits (res.bits),
		.code (code)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {1'b0, code, res.bits, res.changed};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
